[sv/star_glob_matcher_macros.svh]
// assertion macros for the star glob matcher
`ifndef STAR_GLOB_MATCHER_MACROS_SVH
`define STAR_GLOB_MATCHER_MACROS_SVH

// condition holds in the same cycle
`define SGM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define SGM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sgm_pkg.sv]
// shared constants and types of the star glob matcher
package sgm_pkg;

	localparam int unsigned PATTERN_MAX = 32;
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
	localparam logic [7:0] STAR_BYTE = 8'h2A;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_START  = 2'd2,
		MODE_FEED   = 2'd3
	} mode_t;

	typedef struct packed {
		logic       feed;
		logic [7:0] byte_value;
	} cell_ctrl_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} res_t;

endpackage

[sv/sgm_cell.sv]
// one pattern position: stored byte, active bit and closure hand-off
module sgm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               act_init,
	input  sgm_pkg::cell_ctrl_t ctrl,
	input  logic               wr,
	input  logic               used,
	input  logic               shift_in,
	input  logic               carry_in,
	output logic               shift_out,
	output logic               carry_out,
	output logic               act_nxt
);

	logic [7:0] pat_q;
	logic       act_q;
	logic [7:0] pat_eff;
	logic       star_q;
	logic       star_eff;
	logic       base;

	assign pat_eff  = wr ? ctrl.byte_value : pat_q;
	assign star_q   = (pat_q == sgm_pkg::STAR_BYTE);
	assign star_eff = (pat_eff == sgm_pkg::STAR_BYTE);

	// star keeps itself active, a literal hands its match to the right
	assign base      = shift_in | (ctrl.feed & act_q & used & star_q);
	assign act_nxt   = base | carry_in;
	assign carry_out = act_nxt & used & star_eff;
	assign shift_out = ctrl.feed & act_q & used & ~star_q & (pat_q == ctrl.byte_value);

	always_ff @(posedge clk) begin
		if (en && wr) begin
			pat_q <= ctrl.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= act_init;
		end else if (en) begin
			act_q <= act_nxt;
		end
	end

endmodule

[sv/sgm_skid.sv]
// two-entry result buffer between the cell row and the output channel
module sgm_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sgm_pkg::res_t push_res,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output sgm_pkg::res_t out_res
);

	logic          out_valid_q;
	logic          skid_valid_q;
	sgm_pkg::res_t out_res_q;
	sgm_pkg::res_t skid_res_q;
	logic          pop;

	assign pop       = out_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_res_q <= push_res;
			end else begin
				skid_res_q <= push_res;
			end
		end else if (pop && skid_valid_q) begin
			out_res_q <= skid_res_q;
		end
	end

endmodule

[sv/star_glob_matcher.sv]
// top level of the star glob matcher: control, cell row and result buffer
//
// Streams text bytes against a stored glob pattern where '*' matches any run
// of bytes and every other byte matches only itself.
// Input channel: in_valid / in_stall with mode and byte_value. Mode clears
// the pattern, appends a pattern byte, starts a new text or feeds a text byte.
// Output channel: out_valid / out_stall with matched and pattern_overflow,
// one result beat for every input beat, in order.
// The result of each taken beat is registered before it is offered.
// Throughput: one beat per cycle while in_stall is low; every pattern position
// is a cell of a row whose next state is computed combinationally, with star
// closure rippling through the row like a carry chain.
// A stalled result is held in the output register and a second result goes
// to a skid register; in_stall rises only while the skid register is full.
// Up to 32 pattern bytes are kept; further appends are dropped and flag
// pattern_overflow until the next clear.
// Reset: empty pattern, only position zero active, no overflow, both result
// registers empty.
`include "star_glob_matcher_macros.svh"

module star_glob_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       pattern_overflow
);

	localparam int unsigned LW = sgm_pkg::LEN_W;
	localparam int unsigned PM = sgm_pkg::PATTERN_MAX;

	logic [LW-1:0]       len_q;
	logic [LW-1:0]       len_nxt;
	logic                ovf_q;
	logic                ovf_nxt;
	logic                in_acc;
	logic                full;
	sgm_pkg::mode_t      mode_e;
	sgm_pkg::cell_ctrl_t ctrl;
	logic                restart;
	logic                len_room;
	logic [PM:0]         shift_c;
	logic [PM:0]         carry_c;
	logic [PM:0]         act_nxt;
	logic [PM-1:0]       wr_sel;
	logic [PM-1:0]       used;
	sgm_pkg::res_t       res_nxt;
	sgm_pkg::res_t       res_out;

	assign in_stall = full;
	assign in_acc   = in_valid & ~full;
	assign mode_e   = sgm_pkg::mode_t'(mode);
	assign len_room = (len_q < LW'(PM));

	always_comb begin
		len_nxt = len_q;
		ovf_nxt = ovf_q;
		unique case (mode_e)
			sgm_pkg::MODE_CLEAR: begin
				len_nxt = '0;
				ovf_nxt = 1'b0;
			end
			sgm_pkg::MODE_APPEND: begin
				if (len_room) begin
					len_nxt = len_q + LW'(1);
				end else begin
					ovf_nxt = 1'b1;
				end
			end
			default: begin
				len_nxt = len_q;
			end
		endcase
	end

	assign restart         = (mode_e != sgm_pkg::MODE_FEED);
	assign ctrl.feed       = ~restart;
	assign ctrl.byte_value = byte_value;

	// restart seeds position zero
	assign shift_c[0] = restart;
	assign carry_c[0] = 1'b0;

	for (genvar g = 0; g < PM; g++) begin : g_cell
		assign wr_sel[g] = (mode_e == sgm_pkg::MODE_APPEND) && (len_q == LW'(g));
		assign used[g]   = (len_nxt > LW'(g));

		sgm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (in_acc),
			.act_init  (g == 0),
			.ctrl      (ctrl),
			.wr        (wr_sel[g]),
			.used      (used[g]),
			.shift_in  (shift_c[g]),
			.carry_in  (carry_c[g]),
			.shift_out (shift_c[g+1]),
			.carry_out (carry_c[g+1]),
			.act_nxt   (act_nxt[g])
		);
	end

	// end position past a full pattern
	assign act_nxt[PM] = shift_c[PM] | carry_c[PM];

	assign res_nxt.matched          = act_nxt[len_nxt];
	assign res_nxt.pattern_overflow = ovf_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (in_acc) begin
			len_q <= len_nxt;
			ovf_q <= ovf_nxt;
		end
	end

	sgm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_res  (res_nxt),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res_out)
	);

	assign matched          = res_out.matched;
	assign pattern_overflow = res_out.pattern_overflow;

	`SGM_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LW'(PM), "pattern length beyond capacity")
	`SGM_ASSERT_NOW(a_skid_order, full, out_valid, "skid register full with output empty")
	`SGM_ASSERT_NEXT(a_clear, in_acc && mode == sgm_pkg::MODE_CLEAR, len_q == '0 && !ovf_q, "clear did not empty the pattern")
	`SGM_ASSERT_NEXT(a_ovf_set, in_acc && mode == sgm_pkg::MODE_APPEND && !len_room, ovf_q && out_valid, "append when full did not flag overflow")

endmodule

[tb/sv/tb_star_glob_matcher.sv]
// self-checking testbench for the star glob matcher: directed, overflow and random streams
`timescale 1ns / 1ps

module tb_star_glob_matcher;
	import sgm_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	mode_t      mode = MODE_CLEAR;
	logic [7:0] byte_value = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       matched;
	logic       pattern_overflow;

	star_glob_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.matched(matched),
		.pattern_overflow(pattern_overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted matcher state
	logic [7:0]           glob_bytes [PATTERN_MAX];
	int unsigned          glob_len = 0;
	logic [PATTERN_MAX:0] live_pos = 1;
	logic                 dropped = 1'b0;
	res_t                 due_results [$];

	int error_count = 0;
	int beats_sent = 0;
	int results_checked = 0;
	int match_hits = 0;
	int overflow_hits = 0;
	int gap_pct = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_left = 0;
	bit valid_up = 1'b0;
	res_t oldest_due;

	function automatic res_t next_match_result(input mode_t m, input logic [7:0] b);
		res_t r;
		logic [PATTERN_MAX:0] nxt;
		nxt = '0;
		case (m)
		MODE_CLEAR: begin
			glob_len = 0;
			dropped = 1'b0;
			live_pos = 1;
		end
		MODE_APPEND: begin
			if (glob_len < PATTERN_MAX) begin
				glob_bytes[glob_len] = b;
				glob_len++;
			end else begin
				dropped = 1'b1;
			end
			live_pos = 1;
		end
		MODE_START: begin
			live_pos = 1;
		end
		default: begin
			for (int p = 0; p < glob_len; p++) begin
				if (live_pos[p]) begin
					if (glob_bytes[p] == STAR_BYTE)
						nxt[p] = 1'b1;
					else if (glob_bytes[p] == b)
						nxt[p + 1] = 1'b1;
				end
			end
			live_pos = nxt;
		end
		endcase
		// star closure ripples upward
		for (int p = 0; p < glob_len; p++) begin
			if (live_pos[p] && glob_bytes[p] == STAR_BYTE)
				live_pos[p + 1] = 1'b1;
		end
		r.matched = live_pos[glob_len];
		r.pattern_overflow = dropped;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic go_idle(input int cycles);
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_beat(input mode_t m, input logic [7:0] b);
		in_valid <= 1'b1;
		valid_up = 1'b1;
		mode <= m;
		byte_value <= b;
		do
			@(posedge clk);
		while (in_stall);
		due_results.push_back(next_match_result(m, b));
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 99) < gap_pct)
				go_idle($urandom_range(1, 6));
		end
	endtask

	function automatic logic [7:0] pick_letter();
		return 8'h61 + 8'($urandom_range(0, 2));
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			stall_left <= $urandom_range(0, 5);
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				oldest_due = due_results.pop_front();
				results_checked++;
				if (oldest_due.matched) match_hits++;
				if (oldest_due.pattern_overflow) overflow_hits++;
				if (matched !== oldest_due.matched)
					report_mismatch($sformatf("matched %b, expected %b",
						matched, oldest_due.matched));
				if (pattern_overflow !== oldest_due.pattern_overflow)
					report_mismatch($sformatf("pattern_overflow %b, expected %b",
						pattern_overflow, oldest_due.pattern_overflow));
			end
		end
	end

	task automatic test_empty_pattern();
		send_beat(MODE_START, 8'h00);
		send_beat(MODE_FEED, 8'h61);
		send_beat(MODE_START, 8'hFF);
		send_beat(MODE_CLEAR, 8'hFF);
	endtask

	task automatic test_literal();
		send_beat(MODE_APPEND, 8'h61);
		send_beat(MODE_APPEND, 8'h62);
		send_beat(MODE_APPEND, 8'h63);
		send_beat(MODE_START, 8'h00);
		send_beat(MODE_FEED, 8'h61);
		send_beat(MODE_FEED, 8'h62);
		send_beat(MODE_FEED, 8'h63);
		send_beat(MODE_FEED, 8'h63);
	endtask

	task automatic test_stars();
		send_beat(MODE_CLEAR, 8'h00);
		send_beat(MODE_APPEND, STAR_BYTE);
		send_beat(MODE_APPEND, STAR_BYTE);
		send_beat(MODE_APPEND, 8'h7A);
		send_beat(MODE_FEED, 8'h7A);
		send_beat(MODE_FEED, 8'h79);
		send_beat(MODE_FEED, 8'h7A);
		send_beat(MODE_APPEND, STAR_BYTE);
		send_beat(MODE_FEED, 8'h7A);
		send_beat(MODE_FEED, STAR_BYTE);
	endtask

	task automatic test_byte_extremes();
		send_beat(MODE_CLEAR, 8'h00);
		send_beat(MODE_APPEND, 8'h00);
		send_beat(MODE_APPEND, 8'hFF);
		send_beat(MODE_FEED, 8'h00);
		send_beat(MODE_FEED, 8'hFF);
	endtask

	task automatic test_overflow();
		logic [7:0] kept [$];
		logic [7:0] b;
		int extra;
		repeat (2) begin
			kept.delete();
			extra = $urandom_range(1, 4);
			send_beat(MODE_CLEAR, 8'($urandom_range(0, 255)));
			for (int i = 0; i < PATTERN_MAX + extra; i++) begin
				b = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) == 0) b = STAR_BYTE;
				if (i < PATTERN_MAX) kept.push_back(b);
				send_beat(MODE_APPEND, b);
			end
			send_beat(MODE_START, 8'($urandom_range(0, 255)));
			foreach (kept[i])
				send_beat(MODE_FEED, kept[i]);
		end
		send_beat(MODE_CLEAR, 8'h00);
	endtask

	task automatic test_random_sessions(input int count);
		logic [7:0] pat [$];
		logic [7:0] txt [$];
		logic [7:0] b;
		int stop_at;
		int plen;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise and broken sequences
				repeat ($urandom_range(1, 6))
					send_beat(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				pat.delete();
				plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 6);
				send_beat(MODE_CLEAR, 8'($urandom_range(0, 255)));
				repeat (plen) begin
					case ($urandom_range(0, 19))
					0: b = 8'($urandom_range(0, 255));
					1, 2, 3, 4, 5, 6: b = STAR_BYTE;
					default: b = pick_letter();
					endcase
					pat.push_back(b);
					send_beat(MODE_APPEND, b);
				end
				repeat ($urandom_range(1, 4)) begin
					txt.delete();
					foreach (pat[i]) begin
						if (pat[i] == STAR_BYTE) begin
							repeat ($urandom_range(0, 3)) txt.push_back(pick_letter());
						end else begin
							txt.push_back(pat[i]);
						end
					end
					if (txt.size() > 0 && $urandom_range(0, 4) == 0)
						txt[$urandom_range(0, txt.size() - 1)] = pick_letter();
					if ($urandom_range(0, 5) == 0)
						txt.push_back(pick_letter());
					send_beat(MODE_START, 8'($urandom_range(0, 255)));
					foreach (txt[i])
						send_beat(MODE_FEED, txt[i]);
				end
			end
		end
	endtask

	task automatic test_drain_pause();
		test_random_sessions(40);
		go_idle(0);
		while (due_results.size() != 0) @(posedge clk);
		test_random_sessions(40);
	endtask

	initial begin
		int wait_left;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pattern();
		test_literal();
		test_stars();
		test_byte_extremes();

		gap_pct = 30;
		stall_pct = 30;
		test_overflow();
		test_random_sessions(550);

		gap_pct = 0;
		stall_pct = 0;
		test_random_sessions(200);

		gap_pct = 60;
		stall_pct = 75;
		test_random_sessions(250);
		test_drain_pause();

		go_idle(0);
		wait_left = 2000;
		while (due_results.size() != 0 && wait_left > 0) begin
			@(posedge clk);
			wait_left--;
		end
		if (due_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_results.size()));
		repeat (4) @(posedge clk);

		$display("sent %0d beats covering clear, append, start and feed, overflow and stars",
			beats_sent);
		$display("checked %0d results: %0d matches, %0d with overflow flagged",
			results_checked, match_hits, overflow_hits);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/sgm_pkg.sv
sv/sgm_cell.sv
sv/sgm_skid.sv
sv/star_glob_matcher.sv
tb/sv/tb_star_glob_matcher.sv
